// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the day-count-to-date RTL.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define DCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define DCD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/dcd_pkg.sv =====
// Package for the day-count-to-date unit: calendar constants, widths and the result struct.
// Depends on nothing.
package dcd_pkg;

	localparam int unsigned MAX_YEAR = 9999;
	localparam int unsigned DAY_W = 22;
	localparam int unsigned LEN_W = 18;
	localparam int unsigned YEAR_BITS = $clog2(MAX_YEAR + 1);
	localparam int unsigned YR_W = (YEAR_BITS > 14) ? YEAR_BITS : 14;

	localparam int unsigned NEXT_YEAR = MAX_YEAR + 1;
	localparam logic [31:0] LAST_DAY = 32'(365 * NEXT_YEAR + (NEXT_YEAR + 3) / 4
		- (NEXT_YEAR + 99) / 100 + (NEXT_YEAR + 399) / 400 - 1);

	localparam logic [LEN_W-1:0] ERA_DAYS = LEN_W'(146097);
	localparam logic [LEN_W-1:0] LEAP_CENT_DAYS = LEN_W'(36525);
	localparam logic [LEN_W-1:0] CENT_DAYS = LEN_W'(36524);
	localparam logic [LEN_W-1:0] QUAD_DAYS = LEN_W'(1461);
	localparam logic [LEN_W-1:0] SHORT_QUAD_DAYS = LEN_W'(1460);
	localparam logic [LEN_W-1:0] LEAP_YEAR_DAYS = LEN_W'(366);
	localparam logic [LEN_W-1:0] YEAR_DAYS = LEN_W'(365);
	localparam logic [4:0] LEAP_FEB_DAYS = 5'd29;
	localparam logic [3:0] FEB_IDX = 4'd1;
	localparam logic [3:0] DEC_IDX = 4'd11;

	localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	typedef struct packed {
		logic        valid;
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [13:0] year_number;
		logic        out_of_range;
	} dcd_res_t;

endpackage

// ===== hdl/day_count_to_date_unit.sv =====
// Top level of the day-count-to-date unit: input handshake, conversion core and output register.
// Depends on dcd_pkg and dcd_core.
//
// The unit turns a zero-based count of days since 1 January of year 0 (proleptic Gregorian)
// into day, month and year, and saturates to 31 December of MAX_YEAR with out_of_range set
// when the count lies past that day. One transaction at a time is converted: in_stall is high
// from acceptance until the core has handed its result to the output register. A single
// subtractor peels one span per cycle, in the order 400-year eras, centuries, four-year groups,
// years in the group and months; a saturated count skips straight to the result. A finished
// result waits in the output register, so the next transaction can be accepted while it is not
// yet taken.
module day_count_to_date_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [dcd_pkg::DAY_W-1:0] day_count,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [4:0]                day_of_month,
	output logic [3:0]                month_number,
	output logic [13:0]               year_number,
	output logic                      out_of_range
);
	import dcd_pkg::*;

	logic     core_idle;
	logic     core_ack;
	dcd_res_t core_res;
	logic     out_valid_q;

	assign in_stall = !core_idle;
	assign core_ack = !out_valid_q || !out_stall;

	dcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid),
		.day_count (day_count),
		.ack       (core_ack),
		.idle      (core_idle),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ack) begin
			out_valid_q <= core_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ack && core_res.valid) begin
			day_of_month <= core_res.day_of_month;
			month_number <= core_res.month_number;
			year_number <= core_res.year_number;
			out_of_range <= core_res.out_of_range;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/dcd_core.sv =====
// Iterative conversion core: peels 400-year, century, four-year, year and month spans
// with one shared subtractor. Depends on dcd_pkg and assert_macros.svh.
module dcd_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dcd_pkg::DAY_W-1:0] day_count,
	input  logic                      ack,
	output logic                      idle,
	output dcd_pkg::dcd_res_t         res
);
	import dcd_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ERA  = 7'b0000010,
		ST_CENT = 7'b0000100,
		ST_QUAD = 7'b0001000,
		ST_YEAR = 7'b0010000,
		ST_MON  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [DAY_W-1:0]   rem_q;
	logic [YR_W-1:0]    year_q;
	logic [1:0]         cent_q;
	logic [4:0]         quad_q;
	logic [1:0]         yq_q;
	logic [3:0]         mon_q;
	logic               oor_q;
	logic               leap;
	logic               too_big;
	logic [LEN_W-1:0]   len_sel;
	logic [YR_W-1:0]    year_step;
	logic [DAY_W:0]     diff;
	logic               fits;

	assign leap = (yq_q == 2'd0) && ((quad_q != 5'd0) || (cent_q == 2'd0));
	assign too_big = {10'd0, day_count} > LAST_DAY;

	always_comb begin
		len_sel = YEAR_DAYS;
		year_step = YR_W'(1);
		unique case (state_q)
			ST_ERA: begin
				len_sel = ERA_DAYS;
				year_step = YR_W'(400);
			end
			ST_CENT: begin
				len_sel = (cent_q == 2'd0) ? LEAP_CENT_DAYS : CENT_DAYS;
				year_step = YR_W'(100);
			end
			ST_QUAD: begin
				len_sel = ((quad_q == 5'd0) && (cent_q != 2'd0)) ? SHORT_QUAD_DAYS : QUAD_DAYS;
				year_step = YR_W'(4);
			end
			ST_YEAR: begin
				len_sel = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
			end
			ST_MON: begin
				if ((mon_q == FEB_IDX) && leap) begin
					len_sel = LEN_W'(LEAP_FEB_DAYS);
				end else begin
					len_sel = LEN_W'(MONTH_LEN[mon_q]);
				end
			end
			default: begin
				len_sel = YEAR_DAYS;
			end
		endcase
	end

	assign diff = {1'b0, rem_q} - {{(DAY_W + 1 - LEN_W){1'b0}}, len_sel};
	assign fits = !diff[DAY_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= too_big ? ST_FIN : ST_ERA;
					end
				end
				ST_ERA: begin
					if (!fits) begin
						state_q <= ST_CENT;
					end
				end
				ST_CENT: begin
					if (!fits) begin
						state_q <= ST_QUAD;
					end
				end
				ST_QUAD: begin
					if (!fits) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!fits) begin
						state_q <= ST_MON;
					end
				end
				ST_MON: begin
					if (!fits || (mon_q == DEC_IDX)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cent_q <= 2'd0;
			quad_q <= 5'd0;
			yq_q <= 2'd0;
			if (too_big) begin
				rem_q <= DAY_W'(30);
				mon_q <= DEC_IDX;
				year_q <= YR_W'(MAX_YEAR);
				oor_q <= 1'b1;
			end else begin
				rem_q <= day_count;
				mon_q <= 4'd0;
				year_q <= '0;
				oor_q <= 1'b0;
			end
		end else if (fits && ((state_q == ST_ERA) || (state_q == ST_CENT)
				|| (state_q == ST_QUAD) || (state_q == ST_YEAR))) begin
			rem_q <= diff[DAY_W-1:0];
			year_q <= year_q + year_step;
			if (state_q == ST_CENT) begin
				cent_q <= cent_q + 2'd1;
			end
			if (state_q == ST_QUAD) begin
				quad_q <= quad_q + 5'd1;
			end
			if (state_q == ST_YEAR) begin
				yq_q <= yq_q + 2'd1;
			end
		end else if (fits && (state_q == ST_MON) && (mon_q != DEC_IDX)) begin
			rem_q <= diff[DAY_W-1:0];
			mon_q <= mon_q + 4'd1;
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_FIN);
	assign res.day_of_month = rem_q[4:0] + 5'd1;
	assign res.month_number = mon_q + 4'd1;
	assign res.year_number = year_q[13:0];
	assign res.out_of_range = oor_q;

	`DCD_ASSERT(a_month_ok, res.valid |-> (mon_q <= DEC_IDX), "month index past December")
	`DCD_ASSERT(a_sat_date, res.valid && res.out_of_range |->
		(res.day_of_month == 5'd31) && (res.month_number == 4'd12), "saturated date wrong")
	`DCD_ASSERT(a_start_busy, idle && start |=> !idle, "start did not leave idle")
	`DCD_ASSERT_NEVER(a_day_range, res.valid && (rem_q > DAY_W'(30)), "day past 31")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for day_count_to_date_unit: converts day counts to Gregorian dates.
// Depends on dcd_pkg for the day-count width and MAX_YEAR; a queue-fed driver and a monitor
// compare every output transaction against a date computed inside the bench.
module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_START = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FIRST = 700;
	localparam int CALM_LAST = 1000;
	localparam int IDLE_PERCENT = 27;
	localparam int FEB = 1;
	localparam int DEC = 11;
	localparam longint unsigned ERA_LEN = 146097;
	localparam longint unsigned TOP_YEAR = dcd_pkg::MAX_YEAR;
	localparam logic [dcd_pkg::DAY_W-1:0] COUNT_ONES = '1;

	localparam byte unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned EDGE_OFFSETS [10] = '{0, 30, 31, 58, 59, 60, 333, 334, 364, 365};

	typedef struct packed {
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [13:0] year_number;
		logic        out_of_range;
	} date_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [dcd_pkg::DAY_W-1:0] day_count;
	logic                      out_valid;
	logic                      out_stall;
	logic [4:0]                day_of_month;
	logic [3:0]                month_number;
	logic [13:0]               year_number;
	logic                      out_of_range;

	logic [dcd_pkg::DAY_W-1:0] counts_to_send [$];
	date_t                     dates_due [$];
	logic                      in_taken;
	int                        n_in;
	int                        n_out;
	int                        errors;
	int                        hold_left;
	bit                        hold_done;

	day_count_to_date_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.day_count    (day_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.day_of_month (day_of_month),
		.month_number (month_number),
		.year_number  (year_number),
		.out_of_range (out_of_range)
	);

	function automatic longint unsigned year_start_day(longint unsigned y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic logic [dcd_pkg::DAY_W-1:0] count_of(longint unsigned v);
		return v[dcd_pkg::DAY_W-1:0];
	endfunction

	function automatic longint unsigned month_length(int m, longint unsigned y);
		if (m == FEB && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0)) begin
			return 64'd29;
		end
		return 64'(MONTH_DAYS[m]);
	endfunction

	function automatic date_t date_of_day_count(logic [dcd_pkg::DAY_W-1:0] cnt);
		longint unsigned d;
		longint unsigned y;
		longint unsigned rem;
		longint unsigned len;
		int m;
		date_t r;
		d = 64'(cnt);
		if (d >= year_start_day(TOP_YEAR + 1)) begin
			r.day_of_month = 5'd31;
			r.month_number = 4'(DEC + 1);
			r.year_number = TOP_YEAR[13:0];
			r.out_of_range = 1'b1;
			return r;
		end
		y = (d * 400) / ERA_LEN;
		while (y > 0 && year_start_day(y) > d) begin
			y--;
		end
		while (year_start_day(y + 1) <= d) begin
			y++;
		end
		rem = d - year_start_day(y);
		m = 0;
		len = month_length(m, y);
		while (m < DEC && rem >= len) begin
			rem -= len;
			m++;
			len = month_length(m, y);
		end
		r.day_of_month = 5'(rem + 1);
		r.month_number = 4'(m + 1);
		r.year_number = y[13:0];
		r.out_of_range = 1'b0;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (counts_to_send.size() > 0 &&
			    ((n_in >= CALM_FIRST && n_in < CALM_LAST) ||
			     $urandom_range(99) >= IDLE_PERCENT)) begin
				in_valid <= 1'b1;
				day_count <= counts_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!hold_done && n_out >= HOLD_START) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (n_out >= CALM_FIRST && n_out < CALM_LAST) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		date_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				dates_due.push_back(date_of_day_count(day_count));
				n_in++;
			end
			if (out_valid && !out_stall) begin
				n_out++;
				if (dates_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected output transaction %0d/%0d/%0d oor %0b", $time,
						day_of_month, month_number, year_number, out_of_range);
				end else begin
					want = dates_due.pop_front();
					if (day_of_month !== want.day_of_month) begin
						errors++;
						$display("%0t: day_of_month expected %0d actual %0d", $time,
							want.day_of_month, day_of_month);
					end
					if (month_number !== want.month_number) begin
						errors++;
						$display("%0t: month_number expected %0d actual %0d", $time,
							want.month_number, month_number);
					end
					if (year_number !== want.year_number) begin
						errors++;
						$display("%0t: year_number expected %0d actual %0d", $time,
							want.year_number, year_number);
					end
					if (out_of_range !== want.out_of_range) begin
						errors++;
						$display("%0t: out_of_range expected %0b actual %0b", $time,
							want.out_of_range, out_of_range);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int cycle;
		for (cycle = 0; cycle < CYCLE_LIMIT; cycle++) begin
			@(posedge clk);
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		longint unsigned last;
		longint unsigned base;
		int k;
		int mode;
		arst_n = 1'b0;
		in_valid = 1'b0;
		day_count = '0;
		out_stall = 1'b0;
		in_taken = 1'b0;
		n_in = 0;
		n_out = 0;
		errors = 0;
		hold_left = 0;
		hold_done = 1'b0;
		last = year_start_day(TOP_YEAR + 1) - 1;

		counts_to_send.push_back('0);
		counts_to_send.push_back(count_of(64'd30));
		counts_to_send.push_back(count_of(64'd31));
		counts_to_send.push_back(count_of(64'd59));
		counts_to_send.push_back(count_of(64'd60));
		counts_to_send.push_back(count_of(64'd365));
		counts_to_send.push_back(count_of(64'd366));
		counts_to_send.push_back(count_of(64'd366 + 64'd58));
		counts_to_send.push_back(count_of(64'd366 + 64'd59));
		counts_to_send.push_back(count_of(year_start_day(64'd4) + 59));
		counts_to_send.push_back(count_of(year_start_day(64'd100) - 1));
		counts_to_send.push_back(count_of(year_start_day(64'd100) + 59));
		counts_to_send.push_back(count_of(year_start_day(64'd400) - 1));
		counts_to_send.push_back(count_of(year_start_day(64'd400) + 59));
		counts_to_send.push_back(count_of(year_start_day(64'd1900) + 59));
		counts_to_send.push_back(count_of(year_start_day(64'd2000) + 59));
		counts_to_send.push_back(count_of(year_start_day(TOP_YEAR) + 59));
		counts_to_send.push_back(count_of(last - 1));
		counts_to_send.push_back(count_of(last));
		counts_to_send.push_back(count_of(last + 1));
		counts_to_send.push_back(COUNT_ONES);
		counts_to_send.push_back(22'h2AAAAA);
		counts_to_send.push_back(22'h155555);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			mode = $urandom_range(99);
			if (mode < 50) begin
				counts_to_send.push_back(count_of(64'($urandom_range(int'(last), 0))));
			end else if (mode < 80) begin
				base = year_start_day(64'($urandom_range(int'(TOP_YEAR), 0)));
				counts_to_send.push_back(count_of(base + EDGE_OFFSETS[$urandom_range(9)]));
			end else if (mode < 90) begin
				counts_to_send.push_back(count_of(
					64'($urandom_range(int'(COUNT_ONES), int'(last + 1)))));
			end else begin
				counts_to_send.push_back(count_of(64'($urandom)));
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (counts_to_send.size() != 0 || in_valid || dates_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
